FILE: src/pps_pkg.sv
// Shared constants, codes and link structures of the preemptive priority scheduler.
package pps_pkg;

    localparam int SLOTS = 16;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [2:0] OUT_ACCEPTED  = 3'd0;
    localparam logic [2:0] OUT_DROPPED   = 3'd1;
    localparam logic [2:0] OUT_RAN       = 3'd2;
    localparam logic [2:0] OUT_IDLE      = 3'd3;
    localparam logic [2:0] OUT_COMPLETED = 3'd4;
    localparam logic [2:0] OUT_PREEMPTED = 3'd5;

    // Token that walks the cell row, carrying the best candidate seen so far.
    typedef struct packed {
        logic             tok;
        logic             placed;
        logic             cand_valid;
        logic [IDX_W-1:0] cand_idx;
        logic [7:0]       cand_pid;
        logic [7:0]       cand_prio;
        logic [15:0]      cand_rem;
        logic [15:0]      cand_order;
    } t_carry;

    // Request fields seen by every cell while a token is in flight.
    typedef struct packed {
        logic        op;
        logic [7:0]  pid;
        logic [7:0]  prio;
        logic [15:0] burst;
        logic [15:0] seq;
    } t_bcast;

    // Slot write issued by the controller at the end of a tick sweep.
    typedef struct packed {
        logic             en;
        logic             set;
        logic [IDX_W-1:0] idx;
        logic [7:0]       pid;
        logic [7:0]       prio;
        logic [15:0]      rem;
        logic [15:0]      order;
    } t_wr;

endpackage

FILE: src/pps_cell.sv
// One ready-table slot with its stage of the candidate-selection chain.
module pps_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [pps_pkg::IDX_W-1:0] i_idx,
    input  pps_pkg::t_bcast           i_bc,
    input  pps_pkg::t_wr              i_wr,
    input  pps_pkg::t_carry           i_carry,
    output pps_pkg::t_carry           o_carry
);

    logic            r_valid;
    logic [7:0]      r_pid;
    logic [7:0]      r_prio;
    logic [15:0]     r_rem;
    logic [15:0]     r_order;
    pps_pkg::t_carry r_carry;
    pps_pkg::t_carry n_carry;

    logic [15:0] w_key_own;
    logic [15:0] w_key_in;
    logic        w_better;
    logic        w_take_arr;
    logic        w_wr_hit;

    // Age relative to the next arrival stamp; smaller means earlier.
    assign w_key_own = r_order - i_bc.seq;
    assign w_key_in  = i_carry.cand_order - i_bc.seq;

    // Strictly better only, so ties stay with the lower slot index.
    assign w_better = r_valid &&
                      (!i_carry.cand_valid ||
                       (r_prio < i_carry.cand_prio) ||
                       ((r_prio == i_carry.cand_prio) && (w_key_own < w_key_in)));

    assign w_take_arr = i_carry.tok && (i_bc.op == pps_pkg::OP_ARRIVE) &&
                        !i_carry.placed && !r_valid;

    assign w_wr_hit = i_wr.en && (i_wr.idx == i_idx);

    always_comb begin
        n_carry = i_carry;
        if (i_carry.tok && (i_bc.op == pps_pkg::OP_TICK) && w_better) begin
            n_carry.cand_valid = 1'b1;
            n_carry.cand_idx   = i_idx;
            n_carry.cand_pid   = r_pid;
            n_carry.cand_prio  = r_prio;
            n_carry.cand_rem   = r_rem;
            n_carry.cand_order = r_order;
        end
        if (w_take_arr) begin
            n_carry.placed = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry <= '0;
            r_valid <= 1'b0;
        end else begin
            r_carry <= n_carry;
            if (w_take_arr) begin
                r_valid <= 1'b1;
            end else if (w_wr_hit) begin
                r_valid <= i_wr.set;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_arr) begin
            r_pid   <= i_bc.pid;
            r_prio  <= i_bc.prio;
            r_rem   <= i_bc.burst;
            r_order <= i_bc.seq;
        end else if (w_wr_hit && i_wr.set) begin
            r_pid   <= i_wr.pid;
            r_prio  <= i_wr.prio;
            r_rem   <= i_wr.rem;
            r_order <= i_wr.order;
        end
    end

    assign o_carry = r_carry;

endmodule

FILE: src/preemptive_priority_scheduler.sv
// Top level of the preemptive priority scheduler: controller, running process and cell row.
// A request is latched on acceptance; the token then walks the cell row from slot 0 to the last
// slot, and the result is registered into the output register once it leaves the last cell.
// No new request is taken until the token has left the row and the controller is back in idle.
// A result that waits on the output parks in the hold state and holds back the next acceptance.
// Reset (synchronous, active low) empties the ready table, clears the running process,
// the arrival sequence and the tick counter, and drops any pending result.
module preemptive_priority_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [7:0]  i_proc_id,
    input  logic [15:0] i_burst_len,
    input  logic [7:0]  i_prio_level,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_outcome,
    output logic [7:0]  o_out_proc_id,
    output logic [31:0] o_tick_time
);

    // Controller states: waiting for a request, token in flight, result parked.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_HOLD  = 2'd2;

    logic [1:0]  r_state;

    // Latched request fields, broadcast to every cell during the sweep.
    logic        r_op;
    logic [7:0]  r_pid;
    logic [7:0]  r_prio;
    logic [15:0] r_burst;
    logic        r_head_tok;

    // The running process and the global counters.
    logic        r_run_valid;
    logic [7:0]  r_run_pid;
    logic [7:0]  r_run_prio;
    logic [15:0] r_run_rem;
    logic [15:0] r_run_order;
    logic [15:0] r_arrival_seq;
    logic [31:0] r_tick_count;

    logic        n_run_valid;
    logic [7:0]  n_run_pid;
    logic [7:0]  n_run_prio;
    logic [15:0] n_run_rem;
    logic [15:0] n_run_order;

    // Output register and the parked result used when the output is still occupied.
    logic        r_o_valid;
    logic [2:0]  r_o_outcome;
    logic [7:0]  r_o_pid;
    logic [31:0] r_o_time;
    logic [2:0]  r_p_outcome;
    logic [7:0]  r_p_pid;
    logic [31:0] r_p_time;

    logic [2:0]  w_res_outcome;
    logic [7:0]  w_res_pid;

    pps_pkg::t_bcast w_bc;
    pps_pkg::t_wr    w_sched_wr;
    pps_pkg::t_wr    w_wr;
    pps_pkg::t_carry w_chain [pps_pkg::SLOTS+1];
    pps_pkg::t_carry w_last;
    logic [pps_pkg::SLOTS:0] w_tok_vec;

    logic w_in_acc;
    logic w_done;
    logic w_out_free;
    logic w_load_out;

    assign o_ready    = (r_state == ST_IDLE);
    assign w_in_acc   = i_valid && o_ready;
    assign w_last     = w_chain[pps_pkg::SLOTS];
    assign w_done     = (r_state == ST_SWEEP) && w_last.tok;
    assign w_out_free = !r_o_valid || i_ready;

    // A finished or parked result moves into the output register once it is free.
    assign w_load_out = (w_done || (r_state == ST_HOLD)) && w_out_free;

    assign w_bc = '{op: r_op, pid: r_pid, prio: r_prio, burst: r_burst, seq: r_arrival_seq};

    // The token enters the row at slot 0 with an empty candidate.
    assign w_chain[0] = '{tok: r_head_tok, default: '0};

    // Slot i sits in cell i; the token moves one cell per cycle toward the last slot.
    for (genvar g = 0; g < pps_pkg::SLOTS; g++) begin : g_cell
        pps_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (pps_pkg::IDX_W'(g)),
            .i_bc    (w_bc),
            .i_wr    (w_wr),
            .i_carry (w_chain[g]),
            .o_carry (w_chain[g+1])
        );
    end

    always_comb begin
        for (int k = 0; k <= pps_pkg::SLOTS; k++) begin
            w_tok_vec[k] = w_chain[k].tok;
        end
    end

    // Scheduling decision once the token leaves the last cell. The best ready
    // entry is in w_last; an arrival is accepted or dropped; on a tick the running process is
    // completed, kept, preempted or replaced, then loses one unit of remaining time if it has any.
    always_comb begin
        n_run_valid   = r_run_valid;
        n_run_pid     = r_run_pid;
        n_run_prio    = r_run_prio;
        n_run_rem     = r_run_rem;
        n_run_order   = r_run_order;
        w_sched_wr    = '0;
        w_res_outcome = pps_pkg::OUT_IDLE;
        w_res_pid     = 8'd0;
        w_sched_wr.idx   = w_last.cand_idx;
        w_sched_wr.pid   = r_run_pid;
        w_sched_wr.prio  = r_run_prio;
        w_sched_wr.rem   = r_run_rem;
        w_sched_wr.order = r_run_order;

        if (r_op == pps_pkg::OP_ARRIVE) begin
            w_res_pid     = r_pid;
            w_res_outcome = w_last.placed ? pps_pkg::OUT_ACCEPTED : pps_pkg::OUT_DROPPED;
        end else begin
            if (r_run_valid && (r_run_rem == 16'd0)) begin
                w_res_outcome = pps_pkg::OUT_COMPLETED;
                w_res_pid     = r_run_pid;
                n_run_valid   = w_last.cand_valid;
            end else if (!r_run_valid) begin
                n_run_valid = w_last.cand_valid;
                if (w_last.cand_valid) begin
                    w_res_outcome = pps_pkg::OUT_RAN;
                    w_res_pid     = w_last.cand_pid;
                end
            end else if (w_last.cand_valid && (w_last.cand_prio < r_run_prio)) begin
                // The preempted process takes over the winner's slot.
                w_res_outcome  = pps_pkg::OUT_PREEMPTED;
                w_res_pid      = r_run_pid;
                w_sched_wr.set = 1'b1;
            end else begin
                w_res_outcome = pps_pkg::OUT_RAN;
                w_res_pid     = r_run_pid;
            end

            // Any case that moves the winner into the running register.
            if (w_last.cand_valid &&
                (!r_run_valid || (r_run_rem == 16'd0) || w_sched_wr.set)) begin
                w_sched_wr.en = 1'b1;
                n_run_pid     = w_last.cand_pid;
                n_run_prio    = w_last.cand_prio;
                n_run_rem     = w_last.cand_rem;
                n_run_order   = w_last.cand_order;
            end

            if (n_run_valid && (n_run_rem != 16'd0)) begin
                n_run_rem = n_run_rem - 16'd1;
            end
        end
    end

    always_comb begin
        w_wr    = w_sched_wr;
        w_wr.en = w_sched_wr.en && w_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_head_tok    <= 1'b0;
            r_run_valid   <= 1'b0;
            r_run_pid     <= 8'd0;
            r_run_prio    <= 8'd0;
            r_run_rem     <= 16'd0;
            r_run_order   <= 16'd0;
            r_arrival_seq <= 16'd0;
            r_tick_count  <= 32'd0;
            r_o_valid     <= 1'b0;
        end else begin
            r_head_tok <= w_in_acc;

            if (w_load_out) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= ST_SWEEP;
                    end
                end
                ST_SWEEP: begin
                    if (w_done) begin
                        if (r_op == pps_pkg::OP_TICK) begin
                            r_run_valid  <= n_run_valid;
                            r_run_pid    <= n_run_pid;
                            r_run_prio   <= n_run_prio;
                            r_run_rem    <= n_run_rem;
                            r_run_order  <= n_run_order;
                            r_tick_count <= r_tick_count + 32'd1;
                        end else if (w_last.placed) begin
                            r_arrival_seq <= r_arrival_seq + 16'd1;
                        end
                        if (w_out_free) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_state <= ST_HOLD;
                        end
                    end
                end
                ST_HOLD: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Request and result payloads.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op    <= i_op;
            r_pid   <= i_proc_id;
            r_prio  <= i_prio_level;
            r_burst <= i_burst_len;
        end
        if (w_done) begin
            r_p_outcome <= w_res_outcome;
            r_p_pid     <= w_res_pid;
            r_p_time    <= r_tick_count;
            if (w_out_free) begin
                r_o_outcome <= w_res_outcome;
                r_o_pid     <= w_res_pid;
                r_o_time    <= r_tick_count;
            end
        end else if ((r_state == ST_HOLD) && w_out_free) begin
            r_o_outcome <= r_p_outcome;
            r_o_pid     <= r_p_pid;
            r_o_time    <= r_p_time;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_outcome     = r_o_outcome;
    assign o_out_proc_id = r_o_pid;
    assign o_tick_time   = r_o_time;

`ifndef SYNTHESIS
    a_single_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_vec))
        else $error("more than one token in the cell row");

    a_idle_no_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (w_tok_vec == '0))
        else $error("token in flight while the controller is idle");

    a_outcome_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_outcome <= pps_pkg::OUT_PREEMPTED))
        else $error("result carries an undefined outcome code");

    a_tick_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && (r_op == pps_pkg::OP_TICK)) |=>
            (r_tick_count == $past(r_tick_count) + 32'd1))
        else $error("tick counter did not advance on a tick");
`endif

endmodule
